>>> src/bfh_pkg.sv
// Shared constants and types for the bloom filter block.
package bfh_pkg;

  localparam logic [31:0] FNV_PRIME    = 32'd16777619;
  localparam logic [31:0] FNV_BASIS    = 32'd2166136261;
  localparam int          STRIDE_SHIFT = 16;

  localparam int CFG_BITS_W  = 17;
  localparam int CFG_HASH_W  = 5;
  localparam int CFG_DATA_W  = 17;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_BITS_USED  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HASH_COUNT = 1'd1;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  typedef struct packed {
    logic done;
    logic pop;
    logic clearing;
  } bfh_stat_t;

endpackage

>>> src/bfh_front.sv
// Front end: byte intake, first hash, ping-pong key buffer and job queue.
module bfh_front
  import bfh_pkg::*;
#(
  parameter int MAX_KEY_LEN = 256,
  parameter int LENW        = 9,
  parameter int AW          = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,
  input  logic            in_tuser,
  input  logic            in_tlast,
  input  bfh_stat_t       stat,
  input  logic [AW:0]     rd_addr,
  output logic [7:0]      rd_data,
  output logic            job_valid,
  output logic            job_op,
  output logic            job_ovf,
  output logic [31:0]     job_h1,
  output logic [LENW-1:0] job_len,
  output logic            job_sel
);

  logic [7:0]      buf_mem [2**(AW+1)];
  logic [7:0]      rd_data_r;
  logic [31:0]     h1_r;
  logic [31:0]     h1_nxt;
  logic [LENW-1:0] len_r;
  logic            ovf_r;
  logic            wsel_r;
  logic [1:0]      outst_r;
  logic            q_op_r  [2];
  logic            q_ovf_r [2];
  logic [31:0]     q_h1_r  [2];
  logic [LENW-1:0] q_len_r [2];
  logic            q_sel_r [2];
  logic            q_wp_r;
  logic            q_rp_r;
  logic [1:0]      q_cnt_r;
  logic            beat;
  logic            room;
  logic            push;

  assign in_tready = !stat.clearing && (outst_r != 2'd2);
  assign beat      = in_tvalid && in_tready;
  assign room      = len_r < LENW'(MAX_KEY_LEN);
  assign push      = beat && in_tlast;
  assign h1_nxt    = 32'((h1_r ^ {24'd0, in_tdata}) * FNV_PRIME);

  always_ff @(posedge clk) begin
    if (beat && room) begin
      buf_mem[{wsel_r, len_r[AW-1:0]}] <= in_tdata;
    end
    rd_data_r <= buf_mem[rd_addr];
  end

  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_r    <= FNV_BASIS;
      len_r   <= '0;
      ovf_r   <= 1'b0;
      wsel_r  <= 1'b0;
      outst_r <= 2'd0;
      q_wp_r  <= 1'b0;
      q_rp_r  <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (beat) begin
        if (in_tlast) begin
          h1_r   <= FNV_BASIS;
          len_r  <= '0;
          ovf_r  <= 1'b0;
          wsel_r <= !wsel_r;
        end else begin
          h1_r  <= h1_nxt;
          ovf_r <= ovf_r || !room;
          if (room) begin
            len_r <= LENW'(len_r + 1'b1);
          end
        end
      end
      if (push) begin
        q_op_r[q_wp_r]  <= in_tuser;
        q_ovf_r[q_wp_r] <= ovf_r || !room;
        q_h1_r[q_wp_r]  <= h1_nxt;
        q_len_r[q_wp_r] <= room ? LENW'(len_r + 1'b1) : len_r;
        q_sel_r[q_wp_r] <= wsel_r;
        q_wp_r          <= !q_wp_r;
      end
      if (stat.pop) begin
        q_rp_r <= !q_rp_r;
      end
      q_cnt_r <= 2'(q_cnt_r + {1'b0, push} - {1'b0, stat.pop});
      outst_r <= 2'(outst_r + {1'b0, push} - {1'b0, stat.done});
    end
  end

  assign job_valid = q_cnt_r != 2'd0;
  assign job_op    = q_op_r[q_rp_r];
  assign job_ovf   = q_ovf_r[q_rp_r];
  assign job_h1    = q_h1_r[q_rp_r];
  assign job_len   = q_len_r[q_rp_r];
  assign job_sel   = q_sel_r[q_rp_r];

endmodule

>>> src/bfh_back.sv
// Back end: second hash pass, probe index reduction and bit store access.
module bfh_back
  import bfh_pkg::*;
#(
  parameter int BIT_CAPACITY = 65536,
  parameter int MAX_HASHES   = 16,
  parameter int LENW         = 9,
  parameter int AW           = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [CFG_BITS_W-1:0] cfg_bits,
  input  logic [CFG_HASH_W-1:0] cfg_hash,
  input  logic                  job_valid,
  input  logic                  job_op,
  input  logic                  job_ovf,
  input  logic [31:0]           job_h1,
  input  logic [LENW-1:0]       job_len,
  input  logic                  job_sel,
  output logic [AW:0]           rd_addr,
  input  logic [7:0]            rd_data,
  output bfh_stat_t             stat,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,
  output logic                  out_tuser
);

  localparam int CAPW = $clog2(BIT_CAPACITY + 1);
  localparam int ROWS = (BIT_CAPACITY + 31) / 32;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int KW   = $clog2(MAX_HASHES + 1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_H2    = 4'd3;
  localparam logic [3:0] S_PSET  = 4'd4;
  localparam logic [3:0] S_DIVLD = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_MRD   = 4'd7;
  localparam logic [3:0] S_MWR   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [31:0]     store [ROWS];
  logic [31:0]     st_rd_r;
  logic            st_we;
  logic [RW-1:0]   st_waddr;
  logic [31:0]     st_wdata;
  logic [RW-1:0]   row;
  logic [4:0]      bit_pos;

  logic [3:0]      state_r,   state_nxt;
  logic            op_r,      op_nxt;
  logic            ovf_r,     ovf_nxt;
  logic            sel_r,     sel_nxt;
  logic [LENW-1:0] len_r,     len_nxt;
  logic [LENW-1:0] pos_r,     pos_nxt;
  logic [31:0]     h1_r,      h1_nxt;
  logic [31:0]     h2_r,      h2_nxt;
  logic [31:0]     acc_r,     acc_nxt;
  logic [31:0]     stride_r,  stride_nxt;
  logic [31:0]     dq_r,      dq_nxt;
  logic [CAPW-1:0] rem_r,     rem_nxt;
  logic [CAPW-1:0] m_r,       m_nxt;
  logic [KW-1:0]   k_r,       k_nxt;
  logic [KW-1:0]   i_r,       i_nxt;
  logic [4:0]      cnt_r,     cnt_nxt;
  logic            pres_r,    pres_nxt;
  logic [RW-1:0]   clr_r,     clr_nxt;
  logic            ov_r,      ov_nxt;
  logic            oc_r,      oc_nxt;
  logic            op2_r,     op2_nxt;
  logic            os_r,      os_nxt;
  logic [CAPW:0]   sh;
  logic            hit;

  assign row     = RW'(rem_r >> 5);
  assign bit_pos = 5'(rem_r % 32);
  assign hit     = st_rd_r[bit_pos];
  assign sh      = {rem_r, dq_r[31]};
  assign rd_addr = {sel_r, pos_r[AW-1:0]};

  always_ff @(posedge clk) begin
    if (st_we) begin
      store[st_waddr] <= st_wdata;
    end
    st_rd_r <= store[row];
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    ovf_nxt    = ovf_r;
    sel_nxt    = sel_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    h1_nxt     = h1_r;
    h2_nxt     = h2_r;
    acc_nxt    = acc_r;
    stride_nxt = stride_r;
    dq_nxt     = dq_r;
    rem_nxt    = rem_r;
    m_nxt      = m_r;
    k_nxt      = k_r;
    i_nxt      = i_r;
    cnt_nxt    = cnt_r;
    pres_nxt   = pres_r;
    clr_nxt    = clr_r;
    ov_nxt     = ov_r && !out_tready;
    oc_nxt     = oc_r;
    op2_nxt    = op2_r;
    os_nxt     = os_r;
    st_we      = 1'b0;
    st_waddr   = row;
    st_wdata   = st_rd_r | (32'd1 << bit_pos);
    stat       = '0;
    stat.clearing = state_r == S_CLR;
    case (state_r)
      S_CLR: begin
        st_we    = 1'b1;
        st_waddr = clr_r;
        st_wdata = '0;
        clr_nxt  = RW'(clr_r + 1'b1);
        if (clr_r == RW'(ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (job_valid) begin
          stat.pop = 1'b1;
          op_nxt   = job_op;
          ovf_nxt  = job_ovf;
          sel_nxt  = job_sel;
          len_nxt  = job_len;
          h1_nxt   = job_h1;
          h2_nxt   = FNV_BASIS ^ job_h1;
          pos_nxt  = '0;
          pres_nxt = 1'b0;
          if (cfg_bits == '0) begin
            m_nxt = CAPW'(1);
          end else if (32'(cfg_bits) > 32'(BIT_CAPACITY)) begin
            m_nxt = CAPW'(BIT_CAPACITY);
          end else begin
            m_nxt = CAPW'(cfg_bits);
          end
          if (cfg_hash == '0) begin
            k_nxt = KW'(1);
          end else if (32'(cfg_hash) > 32'(MAX_HASHES)) begin
            k_nxt = KW'(MAX_HASHES);
          end else begin
            k_nxt = KW'(cfg_hash);
          end
          state_nxt = job_ovf ? S_OUT : S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_H2;
      end
      S_H2: begin
        h2_nxt  = 32'((h2_r ^ {24'd0, rd_data}) * FNV_PRIME);
        pos_nxt = LENW'(pos_r + 1'b1);
        state_nxt = (LENW'(pos_r + 1'b1) == len_r) ? S_PSET : S_RD;
      end
      S_PSET: begin
        acc_nxt    = h1_r;
        stride_nxt = (h2_r == '0) ? ((h1_r >> STRIDE_SHIFT) | 32'd1) : h2_r;
        i_nxt      = '0;
        pres_nxt   = 1'b1;
        state_nxt  = S_DIVLD;
      end
      S_DIVLD: begin
        dq_nxt    = acc_r;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sh >= {1'b0, m_r}) begin
          rem_nxt = CAPW'(sh - {1'b0, m_r});
        end else begin
          rem_nxt = CAPW'(sh);
        end
        dq_nxt  = dq_r << 1;
        cnt_nxt = 5'(cnt_r + 1'b1);
        if (cnt_r == 5'd31) begin
          state_nxt = S_MRD;
        end
      end
      S_MRD: begin
        state_nxt = S_MWR;
      end
      S_MWR: begin
        if (op_r == OP_ADD) begin
          st_we = 1'b1;
        end else if (!hit) begin
          pres_nxt = 1'b0;
        end
        if (KW'(i_r + 1'b1) == k_r) begin
          state_nxt = S_OUT;
        end else begin
          i_nxt     = KW'(i_r + 1'b1);
          acc_nxt   = 32'(acc_r + stride_r);
          state_nxt = S_DIVLD;
        end
      end
      S_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          oc_nxt    = op_r;
          op2_nxt   = (op_r == OP_CHECK) && !ovf_r && pres_r;
          os_nxt    = ovf_r;
          stat.done = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
    op_r     <= op_nxt;
    ovf_r    <= ovf_nxt;
    sel_r    <= sel_nxt;
    len_r    <= len_nxt;
    pos_r    <= pos_nxt;
    h1_r     <= h1_nxt;
    h2_r     <= h2_nxt;
    acc_r    <= acc_nxt;
    stride_r <= stride_nxt;
    dq_r     <= dq_nxt;
    rem_r    <= rem_nxt;
    m_r      <= m_nxt;
    k_r      <= k_nxt;
    i_r      <= i_nxt;
    cnt_r    <= cnt_nxt;
    pres_r   <= pres_nxt;
    oc_r     <= oc_nxt;
    op2_r    <= op2_nxt;
    os_r     <= os_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = oc_r;
  assign out_tdata  = {6'd0, os_r, op2_r};

endmodule

>>> src/bloom_filter_fnv_double_hash.sv
// Top level of the bloom filter with FNV-1a double hashing.
// Usage:
//  Keys enter one byte per beat on in_*: in_tdata is the byte, in_tlast marks
//  the final byte and in_tuser on that beat selects add (0) or check (1).
//  Each key yields one beat on out_*: out_tuser echoes the operation,
//  out_tdata[0] is the check answer, out_tdata[1] flags a key that was too
//  long and was dropped. Registers go through cfg_* while the block is idle.
//  Bytes are taken one per cycle while in_tready is high. After the last byte
//  the back end reads each buffered byte and folds it into the second hash,
//  then, per probe, loads the bit-serial remainder unit, runs it over the
//  32-bit probe value and reads the bit store, writing the bit back on an add.
//  A key that was too long skips the second hash and the probes.
//  A two-entry job queue with two key buffers lets the next key stream in
//  while the back end works. After reset the bit store is swept clear, one
//  32-bit row a cycle across every row of the store, with in_tready low.
//  When out_tready is low the result holds in the output register; the back
//  end then stalls, and in_tready drops once both key buffers are taken.
module bloom_filter_fnv_double_hash
  import bfh_pkg::*;
#(
  parameter int BIT_CAPACITY = 65536,
  parameter int MAX_KEY_LEN  = 256,
  parameter int MAX_HASHES   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // key_byte
  input  logic                   in_tuser,   // op
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [7:0]             out_tdata,  // maybe_present, status, zero fill
  output logic                   out_tuser,  // was_check
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int LENW = $clog2(MAX_KEY_LEN + 1);
  localparam int AW   = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;

  logic [CFG_BITS_W-1:0] bits_r;
  logic [CFG_HASH_W-1:0] hash_r;
  bfh_stat_t             stat;
  logic [AW:0]           rd_addr;
  logic [7:0]            rd_data;
  logic                  job_valid;
  logic                  job_op;
  logic                  job_ovf;
  logic [31:0]           job_h1;
  logic [LENW-1:0]       job_len;
  logic                  job_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= 17'd65536;
      hash_r <= 5'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BITS_USED:  bits_r <= CFG_BITS_W'(cfg_wdata);
        CFG_HASH_COUNT: hash_r <= CFG_HASH_W'(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  bfh_front #(
    .MAX_KEY_LEN (MAX_KEY_LEN),
    .LENW        (LENW),
    .AW          (AW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .stat      (stat),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .job_valid (job_valid),
    .job_op    (job_op),
    .job_ovf   (job_ovf),
    .job_h1    (job_h1),
    .job_len   (job_len),
    .job_sel   (job_sel)
  );

  bfh_back #(
    .BIT_CAPACITY (BIT_CAPACITY),
    .MAX_HASHES   (MAX_HASHES),
    .LENW         (LENW),
    .AW           (AW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_bits   (bits_r),
    .cfg_hash   (hash_r),
    .job_valid  (job_valid),
    .job_op     (job_op),
    .job_ovf    (job_ovf),
    .job_h1     (job_h1),
    .job_len    (job_len),
    .job_sel    (job_sel),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
